// File: rtl/r5bm_pkg.sv
// Package for the RAID5 block map and rebuild engine.
// Holds the sequencer state type, command and status codes, register indexes, array sizes and divider control struct.
package r5bm_pkg;

  localparam int MAX_DISKS       = 16;
  localparam int BLOCKS_PER_DISK = 1024;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_DISK_COUNT   = 2'd0;
  localparam logic [1:0] REG_STRIPE       = 2'd1;
  localparam logic [1:0] REG_PRESENT      = 2'd2;
  localparam logic [1:0] REG_DISK_LENGTH  = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_MODN,
    ST_MAP,
    ST_CHECK,
    ST_READ,
    ST_WAIT,
    ST_XOR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// File: rtl/r5bm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module r5bm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/r5bm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on r5bm_pkg for the control struct.
module r5bm_div #(
  parameter int NW = 20,
  parameter int DW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output r5bm_pkg::div_ctl_t ctl,
  output logic [NW-1:0]     quo,
  output logic [DW-1:0]     rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = '0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[DW-1:0], quo_r[NW-1]};
      quo_nxt = {quo_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt    = trial - {1'b0, den};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign quo       = quo_r;
  assign rem       = rem_r[DW-1:0];

endmodule

// File: rtl/raid5_block_map_and_rebuild.sv
// RAID5 left-symmetric read engine with single-disk XOR rebuild.
// A load is written in the cycle after its transfer; the input is ready again after it.
// A query runs three 20-bit divisions in turn on the shared divider, then maps the block and
// reads the target disk, or XORs the others if it alone is absent; a block past the length,
// bad geometry (checked before any division) or more absent disks miss. One query at a time.
// Reset (rst_n, synchronous) sets registers to 2, 1, 0, 0; the disk store is not cleared.
module raid5_block_map_and_rebuild (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_disk_index,
  input  logic [9:0]  in_block_index,
  input  logic [31:0] in_block_data,
  input  logic [19:0] in_logical_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [31:0] out_read_data
);

  localparam int MAX_DISKS       = r5bm_pkg::MAX_DISKS;
  localparam int BLOCKS_PER_DISK = r5bm_pkg::BLOCKS_PER_DISK;
  localparam int DKW   = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int BKW   = (BLOCKS_PER_DISK > 1) ? $clog2(BLOCKS_PER_DISK) : 1;
  localparam int DEPTH = MAX_DISKS * BLOCKS_PER_DISK;
  localparam int AW    = $clog2(DEPTH);

  logic [4:0]  n_r;
  logic [10:0] s_r;
  logic [15:0] mask_r;
  logic [10:0] len_r;

  r5bm_pkg::state_t state_r, state_nxt;

  logic [19:0] lb_r;
  logic [19:0] d_r;
  logic [19:0] runit_r;
  logic [19:0] rs_r;
  logic [19:0] b_r;
  logic [4:0]  t_r;
  logic [4:0]  p_r;
  logic [4:0]  idx_r;
  logic [31:0] acc_r;
  logic        miss_r;
  logic        st_r;
  logic [31:0] od_r;
  logic        ov_r;

  logic        ld_we_r;
  logic [AW-1:0] ld_addr_r;
  logic [31:0] ld_data_r;

  logic        div_start;
  logic [19:0] div_num;
  logic [15:0] div_den;
  r5bm_pkg::div_ctl_t div_ctl;
  logic [19:0] div_quo;
  logic [15:0] div_rem;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;

  logic        accept;
  logic [15:0] unit;
  logic        geom_bad;
  logic [4:0]  missing;
  logic [10:0] len_eff;
  logic [5:0]  tsum;
  logic [4:0]  tmod;
  logic        t_present;
  logic [63:0] pres_ext;
  logic        post_ok;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == r5bm_pkg::ST_IDLE) && !ld_we_r;
  assign post_ok  = !ov_r || out_ready;
  assign unit     = 16'((n_r - 5'd1) * s_r);
  assign geom_bad = (n_r < 5'd2) || (32'(n_r) > MAX_DISKS) || (s_r == 11'd0);
  assign len_eff  = (32'(len_r) > BLOCKS_PER_DISK) ? 11'(BLOCKS_PER_DISK) : len_r;
  assign pres_ext = 64'(mask_r);

  always_comb begin
    missing = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n_r && !mask_r[i]) begin
        missing = missing + 5'd1;
      end
    end
  end

  always_comb begin
    tsum = 6'(rs_r[4:0]) + 6'(p_r) + 6'd1;
    tmod = (tsum >= 6'(n_r)) ? 5'(tsum - 6'(n_r)) : tsum[4:0];
  end

  assign t_present = pres_ext[t_r];

  always_comb begin
    div_start = 1'b0;
    div_num   = lb_r;
    div_den   = unit;
    unique case (state_r)
      r5bm_pkg::ST_DIV1: begin
        div_start = !div_ctl.busy && (idx_r == 5'd0) && !geom_bad;
      end
      r5bm_pkg::ST_DIV2: begin
        div_num   = runit_r;
        div_den   = 16'(s_r);
        div_start = !div_ctl.busy && (idx_r == 5'd0);
      end
      r5bm_pkg::ST_MODN: begin
        div_num   = d_r;
        div_den   = 16'(n_r);
        div_start = !div_ctl.busy && (idx_r == 5'd0);
      end
      default: ;
    endcase
  end

  r5bm_div #(.NW(20), .DW(16)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .ctl   (div_ctl),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    ram_we    = ld_we_r;
    ram_wdata = ld_data_r;
    ram_addr  = ld_we_r ? ld_addr_r
                        : AW'({idx_r[DKW-1:0], b_r[BKW-1:0]});
    if (state_r == r5bm_pkg::ST_READ && !t_r[4]) begin
      ram_addr = AW'({t_r[DKW-1:0], b_r[BKW-1:0]});
    end
  end

  r5bm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      r5bm_pkg::ST_IDLE:
        if (accept && in_command == r5bm_pkg::CMD_QUERY) begin
          state_nxt = r5bm_pkg::ST_DIV1;
        end
      r5bm_pkg::ST_DIV1:
        if (geom_bad) state_nxt = r5bm_pkg::ST_DONE;
        else if (idx_r == 5'd1 && !div_ctl.busy) state_nxt = r5bm_pkg::ST_DIV2;
      r5bm_pkg::ST_DIV2:
        if (idx_r == 5'd1 && !div_ctl.busy) state_nxt = r5bm_pkg::ST_MODN;
      r5bm_pkg::ST_MODN:
        if (idx_r == 5'd1 && !div_ctl.busy) state_nxt = r5bm_pkg::ST_MAP;
      r5bm_pkg::ST_MAP:   state_nxt = r5bm_pkg::ST_CHECK;
      r5bm_pkg::ST_CHECK:
        if (b_r >= 20'(len_eff)) state_nxt = r5bm_pkg::ST_DONE;
        else if (t_present) state_nxt = r5bm_pkg::ST_READ;
        else if (missing != 5'd1) state_nxt = r5bm_pkg::ST_DONE;
        else state_nxt = r5bm_pkg::ST_XOR;
      r5bm_pkg::ST_READ:  state_nxt = r5bm_pkg::ST_WAIT;
      r5bm_pkg::ST_WAIT:  state_nxt = r5bm_pkg::ST_DONE;
      r5bm_pkg::ST_XOR:
        if (idx_r == n_r) state_nxt = r5bm_pkg::ST_DONE;
      r5bm_pkg::ST_DONE:
        if (post_ok) state_nxt = r5bm_pkg::ST_IDLE;
      default:            state_nxt = r5bm_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers; idx_r doubles as divider phase flag and rebuild disk counter.
  logic        xor_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= r5bm_pkg::ST_IDLE;
      n_r        <= 5'd2;
      s_r        <= 11'd1;
      mask_r     <= 16'd0;
      len_r      <= 11'd0;
      ov_r       <= 1'b0;
      ld_we_r    <= 1'b0;
      idx_r      <= '0;
      xor_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ld_we_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          r5bm_pkg::REG_DISK_COUNT:  n_r    <= cfg_data[4:0];
          r5bm_pkg::REG_STRIPE:      s_r    <= cfg_data[10:0];
          r5bm_pkg::REG_PRESENT:     mask_r <= cfg_data;
          r5bm_pkg::REG_DISK_LENGTH: len_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (accept && in_command == r5bm_pkg::CMD_LOAD) begin
        ld_we_r <= (32'(in_disk_index) < MAX_DISKS) && (32'(in_block_index) < BLOCKS_PER_DISK);
      end
      if (accept) begin
        idx_r <= '0;
        miss_r <= 1'b0;
      end
      if (div_start) idx_r <= 5'd1;
      if (state_r == r5bm_pkg::ST_DIV1 && idx_r == 5'd1 && !div_ctl.busy) begin
        d_r <= div_quo; runit_r <= 20'(div_rem); idx_r <= 5'd0;
      end
      if (state_r == r5bm_pkg::ST_DIV2 && idx_r == 5'd1 && !div_ctl.busy) begin
        rs_r <= div_quo; b_r <= 20'(div_rem); idx_r <= 5'd0;
      end
      if (state_r == r5bm_pkg::ST_MODN && idx_r == 5'd1 && !div_ctl.busy) begin
        p_r <= 5'(n_r - 5'd1 - 5'(div_rem));
        b_r <= 20'(d_r * 20'(s_r)) + b_r;
      end
      if (state_r == r5bm_pkg::ST_MAP) begin
        t_r <= tmod;
      end
      if (state_r == r5bm_pkg::ST_CHECK) begin
        idx_r <= '0; acc_r <= '0; xor_pend_r <= 1'b0;
        miss_r <= (b_r >= 20'(len_eff)) || (!t_present && missing != 5'd1);
      end
      if (state_r == r5bm_pkg::ST_WAIT) acc_r <= ram_rdata;
      if (state_r == r5bm_pkg::ST_XOR) begin
        if (xor_pend_r) acc_r <= acc_r ^ ram_rdata;
        xor_pend_r <= (idx_r != t_r) && (idx_r != n_r);
        if (idx_r != n_r) idx_r <= idx_r + 5'd1;
      end
      if (state_r == r5bm_pkg::ST_DIV1 && geom_bad) miss_r <= 1'b1;
      if (state_r == r5bm_pkg::ST_DONE && post_ok) begin
        ov_r <= 1'b1;
        st_r <= miss_r ? r5bm_pkg::STATUS_MISS : r5bm_pkg::STATUS_OK;
        od_r <= miss_r ? 32'd0 : acc_r;
      end
    end
    if (accept) begin
      lb_r      <= in_logical_block;
      ld_addr_r <= AW'({in_disk_index[DKW-1:0], in_block_index[BKW-1:0]});
      ld_data_r <= in_block_data;
    end
  end

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_read_data = od_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != r5bm_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == r5bm_pkg::ST_DONE) |=> out_valid)
    else $error("result not presented");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == r5bm_pkg::STATUS_MISS) |-> (out_read_data == 32'd0))
    else $error("miss with data");

endmodule

// File: bench/tb.sv
// Self-checking bench for the RAID5 left-symmetric read and rebuild engine.
// Depends on r5bm_pkg and raid5_block_map_and_rebuild; a scoreboard class predicts
// each query answer from its own copy of the disk store and registers.
class raid5_answer_board;
  logic [31:0] disk_words [16][1024];
  bit          word_loaded [16][1024];
  logic [4:0]  n_disks;
  logic [10:0] unit_blocks;
  logic [15:0] avail_mask;
  logic [10:0] length_blocks;
  logic        want_status [$];
  logic [31:0] want_data [$];
  int          errors;

  function new();
    n_disks = 2;
    unit_blocks = 1;
    avail_mask = 0;
    length_blocks = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      r5bm_pkg::REG_DISK_COUNT: n_disks = val[4:0];
      r5bm_pkg::REG_STRIPE: unit_blocks = val[10:0];
      r5bm_pkg::REG_PRESENT: avail_mask = val;
      default: length_blocks = val[10:0];
    endcase
  endfunction

  // Finds a word that a query would read before that word has been loaded.
  function bit find_gap(logic [19:0] lb, output int unsigned dsk, output int unsigned blk);
    int unsigned n, s, unit, d, p, b, t, len, missing;
    dsk = 0;
    blk = 0;
    n = n_disks;
    s = unit_blocks;
    if (n < 2 || n > 16 || s == 0) return 0;
    unit = (n - 1) * s;
    d = lb / unit;
    p = n - 1 - (d % n);
    b = d * s + (lb % s);
    t = ((lb % unit) / s + p + 1) % n;
    len = (length_blocks > 1024) ? 1024 : length_blocks;
    if (b >= len) return 0;
    blk = b;
    if (avail_mask[t]) begin
      dsk = t;
      return !word_loaded[t][b];
    end
    missing = 0;
    for (int i = 0; i < n; i++) if (!avail_mask[i]) missing++;
    if (missing != 1) return 0;
    for (int i = 0; i < n; i++) begin
      if (i != t && !word_loaded[i][b]) begin
        dsk = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function void note_input(logic cmd, logic [3:0] dsk, logic [9:0] blk, logic [31:0] dat,
                           logic [19:0] lb);
    int unsigned n, s, unit, d, p, b, t, len, missing;
    logic [31:0] acc;
    if (cmd == r5bm_pkg::CMD_LOAD) begin
      disk_words[dsk][blk] = dat;
      word_loaded[dsk][blk] = 1;
      return;
    end
    n = n_disks;
    s = unit_blocks;
    if (n < 2 || n > 16 || s == 0) begin
      push(r5bm_pkg::STATUS_MISS, 0);
      return;
    end
    unit = (n - 1) * s;
    d = lb / unit;
    p = n - 1 - (d % n);
    b = d * s + (lb % s);
    t = ((lb % unit) / s + p + 1) % n;
    len = (length_blocks > 1024) ? 1024 : length_blocks;
    if (b >= len) begin
      push(r5bm_pkg::STATUS_MISS, 0);
      return;
    end
    if (avail_mask[t]) begin
      push(r5bm_pkg::STATUS_OK, disk_words[t][b]);
      return;
    end
    missing = 0;
    for (int i = 0; i < n; i++) if (!avail_mask[i]) missing++;
    if (missing != 1) begin
      push(r5bm_pkg::STATUS_MISS, 0);
      return;
    end
    acc = 0;
    for (int i = 0; i < n; i++) if (i != t) acc ^= disk_words[i][b];
    push(r5bm_pkg::STATUS_OK, acc);
  endfunction

  function void push(logic st, logic [31:0] dat);
    want_status.push_back(st);
    want_data.push_back(dat);
  endfunction

  function void check_result(logic st, logic [31:0] dat);
    logic es;
    logic [31:0] ed;
    if (want_status.size() == 0) begin
      $display("%0t: unexpected result status=%0d data=%h", $time, st, dat);
      errors++;
      return;
    end
    es = want_status.pop_front();
    ed = want_data.pop_front();
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
    if (dat !== ed) begin
      $display("%0t: read_data expected %h actual %h", $time, ed, dat);
      errors++;
    end
  endfunction
endclass

module tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [3:0]  in_disk_index;
  logic [9:0]  in_block_index;
  logic [31:0] in_block_data;
  logic [19:0] in_logical_block;
  logic        out_valid;
  logic        out_ready;
  logic        out_status;
  logic [31:0] out_read_data;

  raid5_answer_board board;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned sent_items;

  raid5_block_map_and_rebuild u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver stall pattern changes mode every so often.
  always @(posedge clk) begin
    if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count[3:0] < 10);
    endcase
    if (rst_n && out_valid && out_ready) board.check_result(out_status, out_read_data);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_geometry(int n, int s, int mask, int len);
    write_reg(r5bm_pkg::REG_DISK_COUNT, 16'(n));
    write_reg(r5bm_pkg::REG_STRIPE, 16'(s));
    write_reg(r5bm_pkg::REG_PRESENT, 16'(mask));
    write_reg(r5bm_pkg::REG_DISK_LENGTH, 16'(len));
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.want_status.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic [3:0] dsk, logic [9:0] blk, logic [31:0] dat,
                           logic [19:0] lb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    in_command <= cmd;
    in_disk_index <= dsk;
    in_block_index <= blk;
    in_block_data <= dat;
    in_logical_block <= lb;
    do @(posedge clk); while (!in_ready);
    board.note_input(cmd, dsk, blk, dat, lb);
    sent_items++;
  endtask

  // Loads every word the query would read that has not been loaded yet, then sends it.
  task automatic send_query(logic [19:0] lb);
    int unsigned dsk, blk;
    while (board.find_gap(lb, dsk, blk)) begin
      send_item(r5bm_pkg::CMD_LOAD, 4'(dsk), 10'(blk), $urandom, 20'($urandom));
    end
    send_item(r5bm_pkg::CMD_QUERY, 4'($urandom), 10'($urandom), $urandom, lb);
  endtask

  task automatic load_word(int dsk, int blk);
    send_item(r5bm_pkg::CMD_LOAD, 4'(dsk), 10'(blk), $urandom, 20'($urandom));
  endtask

  // Most queries reach a little past the length; every word read is loaded first.
  task automatic random_phase(int count, int n, int s, int mask, int len);
    int unsigned lb;
    int unsigned stop;
    set_geometry(n, s, mask, len);
    stop = sent_items + count;
    while (sent_items < stop) begin
      if ($urandom_range(0, 3) == 0) begin
        load_word($urandom_range(0, 15), $urandom_range(0, 1023));
      end else begin
        lb = $urandom_range(0, 1048575);
        if ($urandom_range(0, 4) != 0) lb = lb % ((len + 8) * (n - 1) + 1);
        send_query(20'(lb));
      end
    end
    drain();
  endtask

  function automatic int rand_mask(int n);
    int m;
    m = $urandom;
    case ($urandom_range(0, 2))
      0: m = 16'hFFFF;
      1: m = 16'hFFFF ^ (1 << $urandom_range(0, n - 1));
      default: m = $urandom;
    endcase
    return m;
  endfunction

  initial begin
    int n;
    board = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    in_command = 0;
    in_disk_index = 0;
    in_block_index = 0;
    in_block_data = 0;
    in_logical_block = 0;
    out_ready = 0;
    stall_mode = 0;
    burst_left = 0;
    sent_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: reset registers give length zero, then bad geometry,
    // extremes, absent target rebuild and too many absent disks.
    send_query(0);
    drain();
    set_geometry(0, 1, 16'hFFFF, 1024);
    send_query(5);
    drain();
    set_geometry(17, 1, 16'hFFFF, 1024);
    send_query(5);
    drain();
    set_geometry(4, 0, 16'hFFFF, 1024);
    send_query(5);
    drain();
    set_geometry(16, 1024, 16'hFFFF, 2047);
    send_query(20'hFFFFF);
    send_query(0);
    send_item(r5bm_pkg::CMD_LOAD, 4'hF, 10'h3FF, 32'h0, 20'hFFFFF);
    send_query(1023);
    drain();
    set_geometry(3, 1, 16'b011, 10);
    send_query(0);
    send_query(1);
    send_query(2);
    send_query(19);
    send_query(20);
    drain();
    set_geometry(3, 1, 16'b001, 10);
    send_query(1);
    send_query(0);
    drain();
    set_geometry(2, 1, 16'hFFFC, 1);
    send_query(0);
    drain();
    // Random phases over many geometries, including the extremes.
    random_phase(150, 2, 1, rand_mask(2), 1024);
    random_phase(150, 16, 1024, rand_mask(16), 1024);
    for (int ph = 0; ph < 10; ph++) begin
      n = $urandom_range(2, 16);
      random_phase(150, n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                   : $urandom_range(1, 8), rand_mask(n), $urandom_range(0, 1024));
    end
    drain();
    if (board.errors == 0 && board.want_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
